FILE: hw/rtl/ray_box_slab_intersection_top_assert.svh
// Assertion macros for the ray/box slab test block
`ifndef RAY_BOX_SLAB_INTERSECTION_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RBS_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// implication with a fixed delay in cycles
`define RBS_AST_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rbs delayed assertion failed");

`endif

FILE: hw/rtl/rbs_pkg.sv
`default_nettype none
package rbs_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DEN_W   = COORD_W;
  localparam int QW      = COORD_W;
  localparam int NUM_W   = DIFF_W + COORD_FRAC_BITS;
  localparam int CMP_W   = DEN_W + QW;
  localparam int THR_W   = 16;
  localparam int DIST_W  = 31;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // pipeline depth: input reg, 2 front stages, divider, 4 merge stages
  localparam int FRONT_LAT = 2;
  localparam int DIV_LAT   = QW + 1;
  localparam int MERGE_LAT = 4;
  localparam int LAT       = 1 + FRONT_LAT + DIV_LAT + MERGE_LAT;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } rbs_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
  } rbs_out_t;

  // per-axis flags that bypass the divider
  typedef struct packed {
    logic par;
    logic pmiss;
  } rbs_side_t;

  // one division request
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             ovf;
  } rbs_divreq_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ray_box_slab_intersection_top.sv
`default_nettype none
// Ray versus axis-aligned box slab test, signed fixed point.
// Input: in_data carries ray origin, direction and box corners; an item
//   transfers on a clock edge with start high and busy low. busy stays low,
//   so one ray can be taken every cycle.
// Output: out_valid is high for one cycle with out_data (hit flag and
//   distance). The receiver cannot stall; a result must be taken when shown.
// Pipeline: input register, two setup stages, a 32-stage restoring
//   divider plus a saturation stage (six lanes in parallel), and four
//   merge stages. Throughput is one item per cycle, set by the fully
//   pipelined divider lanes.
// Configuration: cfg_data holds the parallel threshold; cfg_ready is
//   always high. Write it only while no item is in flight.
// Reset: rst_n (synchronous, active low) clears the valid pipeline and
//   sets the threshold to 1; items in flight are dropped.
module ray_box_slab_intersection_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire rbs_pkg::rbs_in_t          in_data,
  output logic                           out_valid,
  output rbs_pkg::rbs_out_t              out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rbs_pkg::THR_W-1:0] cfg_data
);
  import rbs_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [LAT-1:0]   vld_r;
  rbs_in_t          in_r;
  logic signed [31:0] o_a [3], d_a [3], lo_a [3], hi_a [3];
  rbs_divreq_t      req_lo [3], req_hi [3];
  rbs_side_t        side_f [3];
  rbs_side_t        side_d_r [DIV_LAT][3];
  logic signed [31:0] t1 [3], t2 [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start && !busy};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    o_a  = '{in_r.origin_x, in_r.origin_y, in_r.origin_z};
    d_a  = '{in_r.direction_x, in_r.direction_y, in_r.direction_z};
    lo_a = '{in_r.box_min_x, in_r.box_min_y, in_r.box_min_z};
    hi_a = '{in_r.box_max_x, in_r.box_max_y, in_r.box_max_z};
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_front u_front (
      .clk(clk), .o_i(o_a[a]), .d_i(d_a[a]), .lo_i(lo_a[a]), .hi_i(hi_a[a]),
      .thr_i(thr_r), .req_lo_o(req_lo[a]), .req_hi_o(req_hi[a]), .side_o(side_f[a])
    );
    rbs_div u_div_lo (.clk(clk), .req_i(req_lo[a]), .t_o(t1[a]));
    rbs_div u_div_hi (.clk(clk), .req_i(req_hi[a]), .t_o(t2[a]));
  end

  // parallel flags ride alongside the divider
  always_ff @(posedge clk) begin
    side_d_r[0] <= side_f;
    for (int s = 1; s < DIV_LAT; s++) begin
      side_d_r[s] <= side_d_r[s-1];
    end
  end

  rbs_merge u_merge (
    .clk(clk), .t1_i(t1), .t2_i(t2), .side_i(side_d_r[DIV_LAT-1]), .res_o(out_data)
  );

  assign out_valid = vld_r[LAT-1];
endmodule
`default_nettype wire

FILE: hw/rtl/rbs_front.sv
`default_nettype none
module rbs_front (
  input  wire                            clk,
  input  wire logic signed [31:0]        o_i,
  input  wire logic signed [31:0]        d_i,
  input  wire logic signed [31:0]        lo_i,
  input  wire logic signed [31:0]        hi_i,
  input  wire logic [rbs_pkg::THR_W-1:0] thr_i,
  output rbs_pkg::rbs_divreq_t           req_lo_o,
  output rbs_pkg::rbs_divreq_t           req_hi_o,
  output rbs_pkg::rbs_side_t             side_o
);
  import rbs_pkg::*;

  logic signed [DIFF_W-1:0] dlo, dhi, dlo_r, dhi_r;
  logic [DEN_W-1:0]         dmag, dmag_r;
  logic                     dneg_r;
  logic [THR_W-1:0]         thr_eff;
  rbs_side_t                side_nxt, side_r, side2_r;
  logic [DIFF_W-1:0]        mlo, mhi;
  rbs_divreq_t              rlo_nxt, rhi_nxt, rlo_r, rhi_r;

  // stage 1: slab differences, direction magnitude, parallel test
  always_comb begin
    dlo = {lo_i[31], lo_i} - {o_i[31], o_i};
    dhi = {hi_i[31], hi_i} - {o_i[31], o_i};
    dmag = d_i[31] ? DEN_W'(~d_i + 32'sd1) : DEN_W'(d_i);
    thr_eff = (thr_i == '0) ? THR_W'(1) : thr_i;
    side_nxt.par = dmag < DEN_W'(thr_eff);
    side_nxt.pmiss = (o_i < lo_i) || (o_i > hi_i);
  end

  always_ff @(posedge clk) begin
    dlo_r  <= dlo;
    dhi_r  <= dhi;
    dmag_r <= dmag;
    dneg_r <= d_i[31];
    side_r <= side_nxt;
  end

  // stage 2: unsigned numerators, quotient sign, overflow check
  always_comb begin
    mlo = dlo_r[DIFF_W-1] ? (~dlo_r + DIFF_W'(1)) : dlo_r;
    mhi = dhi_r[DIFF_W-1] ? (~dhi_r + DIFF_W'(1)) : dhi_r;
    rlo_nxt.num = {mlo, {COORD_FRAC_BITS{1'b0}}};
    rhi_nxt.num = {mhi, {COORD_FRAC_BITS{1'b0}}};
    rlo_nxt.den = dmag_r;
    rhi_nxt.den = dmag_r;
    rlo_nxt.neg = dlo_r[DIFF_W-1] != dneg_r;
    rhi_nxt.neg = dhi_r[DIFF_W-1] != dneg_r;
    rlo_nxt.ovf = CMP_W'(rlo_nxt.num) >= {dmag_r, {QW{1'b0}}};
    rhi_nxt.ovf = CMP_W'(rhi_nxt.num) >= {dmag_r, {QW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    rlo_r   <= rlo_nxt;
    rhi_r   <= rhi_nxt;
    side2_r <= side_r;
  end

  assign req_lo_o = rlo_r;
  assign req_hi_o = rhi_r;
  assign side_o   = side2_r;
endmodule
`default_nettype wire

FILE: hw/rtl/rbs_div.sv
`default_nettype none
module rbs_div (
  input  wire                        clk,
  input  wire rbs_pkg::rbs_divreq_t  req_i,
  output logic signed [31:0]         t_o
);
  import rbs_pkg::*;

  // restoring divider, one quotient bit per stage, MSB first
  logic [NUM_W-1:0] rem_r [QW+1];
  logic [DEN_W-1:0] den_r [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic             neg_r [QW+1];
  logic             ovf_r [QW+1];
  logic signed [31:0] t_nxt, t_r;

  always_comb begin
    rem_r[0] = req_i.num;
    den_r[0] = req_i.den;
    q_r[0]   = '0;
    neg_r[0] = req_i.neg;
    ovf_r[0] = req_i.ovf;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CMP_W-1:0] sub;
    logic             ge;
    always_comb begin
      sub = CMP_W'(den_r[k]) << (QW - 1 - k);
      ge  = CMP_W'(rem_r[k]) >= sub;
    end
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? NUM_W'(CMP_W'(rem_r[k]) - sub) : rem_r[k];
      den_r[k+1] <= den_r[k];
      q_r[k+1]   <= {q_r[k][QW-2:0], ge};
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  // sign and saturation
  always_comb begin
    if (ovf_r[QW]) begin
      t_nxt = neg_r[QW] ? T_MIN : T_MAX;
    end else if (neg_r[QW]) begin
      t_nxt = (q_r[QW] > QW'(T_MIN)) ? T_MIN : signed'(~q_r[QW] + QW'(1));
    end else begin
      t_nxt = q_r[QW][QW-1] ? T_MAX : signed'(q_r[QW]);
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  assign t_o = t_r;
endmodule
`default_nettype wire

FILE: hw/rtl/rbs_merge.sv
`default_nettype none
module rbs_merge (
  input  wire                       clk,
  input  wire logic signed [31:0]   t1_i [3],
  input  wire logic signed [31:0]   t2_i [3],
  input  wire rbs_pkg::rbs_side_t   side_i [3],
  output rbs_pkg::rbs_out_t         res_o
);
  import rbs_pkg::*;

  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic miss1_r, miss2_r, miss3_r;
  logic signed [31:0] n2_r, f2_r, lo2_r, hi2_r, n3_r, f3_r;
  rbs_out_t res_nxt, res_r;

  // M1: order entry/exit, parallel axes leave the interval open
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (side_i[a].par) begin
        lo_r[a] <= T_MIN;
        hi_r[a] <= T_MAX;
      end else begin
        lo_r[a] <= (t1_i[a] > t2_i[a]) ? t2_i[a] : t1_i[a];
        hi_r[a] <= (t1_i[a] > t2_i[a]) ? t1_i[a] : t2_i[a];
      end
    end
    miss1_r <= (side_i[0].par & side_i[0].pmiss) | (side_i[1].par & side_i[1].pmiss) |
               (side_i[2].par & side_i[2].pmiss);
  end

  // M2: merge x and y
  always_ff @(posedge clk) begin
    n2_r    <= (lo_r[1] > lo_r[0]) ? lo_r[1] : lo_r[0];
    f2_r    <= (hi_r[1] < hi_r[0]) ? hi_r[1] : hi_r[0];
    lo2_r   <= lo_r[2];
    hi2_r   <= hi_r[2];
    miss2_r <= miss1_r;
  end

  // M3: merge z
  always_ff @(posedge clk) begin
    n3_r    <= (lo2_r > n2_r) ? lo2_r : n2_r;
    f3_r    <= (hi2_r < f2_r) ? hi2_r : f2_r;
    miss3_r <= miss2_r;
  end

  // M4: hit decision and distance
  always_comb begin
    res_nxt.hit = !miss3_r && !f3_r[31] && (n3_r <= f3_r);
    if (!res_nxt.hit) begin
      res_nxt.hit_distance = '0;
    end else begin
      res_nxt.hit_distance = n3_r[31] ? f3_r[DIST_W-1:0] : n3_r[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;
endmodule
`default_nettype wire

FILE: hw/rtl/rbs_checker.sv
`default_nettype none
`include "ray_box_slab_intersection_top_assert.svh"
module rbs_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            start,
  input wire                            busy,
  input wire rbs_pkg::rbs_out_t         out_data,
  input wire                            out_valid,
  input wire                            cfg_valid,
  input wire                            cfg_ready
);
  import rbs_pkg::*;

  `RBS_AST_IMPL(a_never_busy, 1'b1, !busy && cfg_ready)
  `RBS_AST_IMPL(a_miss_zero, out_valid && !out_data.hit, out_data.hit_distance == '0)
  `RBS_AST_DLY(a_result_follows, start && !busy, LAT, out_valid)
  `RBS_AST_IMPL(a_no_orphan, out_valid, $past(start, LAT))

endmodule

bind ray_box_slab_intersection_top rbs_checker u_rbs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_data(out_data),
  .out_valid(out_valid), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire
